@@ rtl/ps2_mouse_packet_cursor_tracker_defines.svh @@
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker assertion macros
// Shared property wrappers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define PS2MCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PS2MCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ps2mct_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Types and constants shared by the PS/2 / USB mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  // Cursor coordinate width (clamp cap is 2^COORD_BITS - 1)
  localparam int COORD_BITS = 16;
  // Config register / screen size width
  localparam int CFG_W      = 16;
  // Cursor width on the result channel
  localparam int OUT_W      = 16;
  // Working width of the signed add-and-clamp
  localparam int SUM_W      = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 2;

  // Config register indexes
  localparam logic CFG_HSIZE = 1'b0;
  localparam logic CFG_VSIZE = 1'b1;

  localparam logic [CFG_W-1:0] HSIZE_RST = 16'd1024;
  localparam logic [CFG_W-1:0] VSIZE_RST = 16'd768;

  // Bit positions in status, packet header and button bytes
  localparam int STAT_DATA_BIT = 0;
  localparam int STAT_AUX_BIT  = 5;
  localparam int HDR_SYNC_BIT  = 3;
  localparam int BTN_LEFT_BIT  = 0;
  localparam int BTN_RIGHT_BIT = 1;

  typedef enum logic {
    OP_PS2 = 1'b0,
    OP_USB = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_KBD  = 2'd1,
    EV_PKT  = 2'd2,
    EV_MOVE = 2'd3
  } ev_kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XDELTA = 2'd1,
    PH_YDELTA = 2'd2
  } phase_t;

  typedef struct packed {
    logic              operation;
    logic [7:0]        status_byte;
    logic [7:0]        data_byte;
    logic signed [7:0] usb_dx;
    logic signed [7:0] usb_dy;
    logic [7:0]        usb_buttons;
  } ps2mct_in_t;

  typedef struct packed {
    ev_kind_t         event_kind;
    logic [7:0]       keyboard_byte;
    logic [OUT_W-1:0] cursor_x;
    logic [OUT_W-1:0] cursor_y;
    logic             left_pressed;
    logic             right_pressed;
  } ps2mct_out_t;

  // Tracker state carried from one request to the next
  typedef struct packed {
    phase_t                phase;
    logic [7:0]            header;
    logic [7:0]            xdelta;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  left;
    logic                  right;
  } ps2mct_state_t;

endpackage

@@ rtl/ps2mct_step.sv @@
// ----------------------------------------------------------------------------
// ps2mct_step
// One request's worth of decode: packet assembly, cursor move and clamp.
// ----------------------------------------------------------------------------
module ps2mct_step
  import ps2mct_pkg::*;
(
  input  ps2mct_in_t         item,
  input  ps2mct_state_t      cur,
  input  logic [CFG_W-1:0]   hsize,
  input  logic [CFG_W-1:0]   vsize,
  output ps2mct_state_t      nxt,
  output ps2mct_out_t        result
);

  localparam logic [SUM_W-1:0] COORD_CAP =
    {{(SUM_W-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

  // pos + delta, clamped to [0, min(size-1, cap)]; size 0 acts as 1
  function automatic logic [COORD_BITS-1:0] clamp_move(
    input logic [COORD_BITS-1:0] pos,
    input logic [8:0]            delta,
    input logic [CFG_W-1:0]      size
  );
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] top;
    logic [COORD_BITS-1:0] res;
    sum = SUM_W'(pos) + {{(SUM_W-9){delta[8]}}, delta};
    top = (size == '0) ? '0 : (SUM_W'(size) - SUM_W'(1));
    if (top > COORD_CAP) top = COORD_CAP;
    if (sum[SUM_W-1])    res = '0;
    else if (sum > top)  res = top[COORD_BITS-1:0];
    else                 res = sum[COORD_BITS-1:0];
    return res;
  endfunction

  logic       status_data;
  logic       status_aux;
  logic       do_move;
  logic [8:0] dx;
  logic [8:0] dy;
  logic [7:0] buttons;
  ev_kind_t   kind;
  logic [7:0] kbd;

  assign status_data = item.status_byte[STAT_DATA_BIT];
  assign status_aux  = item.status_byte[STAT_AUX_BIT];

  // Decode the request and advance the packet phase
  always_comb begin
    nxt     = cur;
    do_move = 1'b0;
    dx      = '0;
    dy      = '0;
    buttons = '0;
    kind    = EV_NONE;
    kbd     = '0;
    if (op_t'(item.operation) == OP_USB) begin
      do_move = 1'b1;
      dx      = {item.usb_dx[7], item.usb_dx};
      dy      = {item.usb_dy[7], item.usb_dy};
      buttons = item.usb_buttons;
      kind    = EV_MOVE;
    end else if (!status_data) begin
      kind = EV_NONE;
    end else if (!status_aux) begin
      kind = EV_KBD;
      kbd  = item.data_byte;
    end else begin
      unique case (cur.phase)
        PH_XDELTA: begin
          nxt.xdelta = item.data_byte;
          nxt.phase  = PH_YDELTA;
          kind       = EV_PKT;
        end
        PH_YDELTA: begin
          nxt.phase = PH_HEADER;
          do_move   = 1'b1;
          dx        = {cur.xdelta[7], cur.xdelta};
          // packet Y is up-positive, screen Y is down-positive
          dy        = 9'd0 - {item.data_byte[7], item.data_byte};
          buttons   = cur.header;
          kind      = EV_MOVE;
        end
        default: begin
          // header slot; unmarked bytes are dropped to resync
          nxt.phase = PH_HEADER;
          if (item.data_byte[HDR_SYNC_BIT]) begin
            nxt.header = item.data_byte;
            nxt.phase  = PH_XDELTA;
            kind       = EV_PKT;
          end
        end
      endcase
    end

    if (do_move) begin
      nxt.left  = buttons[BTN_LEFT_BIT];
      nxt.right = buttons[BTN_RIGHT_BIT];
      nxt.pos_x = clamp_move(cur.pos_x, dx, hsize);
      nxt.pos_y = clamp_move(cur.pos_y, dy, vsize);
    end
  end

  // Result reflects the state after this request
  always_comb begin
    result.event_kind    = kind;
    result.keyboard_byte = kbd;
    result.cursor_x      = OUT_W'(SUM_W'(nxt.pos_x));
    result.cursor_y      = OUT_W'(SUM_W'(nxt.pos_y));
    result.left_pressed  = nxt.left;
    result.right_pressed = nxt.right;
  end

endmodule

@@ rtl/ps2_mouse_packet_cursor_tracker.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// Decodes PS/2 controller bytes and USB mouse reports into cursor position,
// button state and forwarded keyboard bytes.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake           Payload
//  in_       in    in_valid/in_ready   ps2mct_in_t  (one byte or USB report)
//  out_      out   out_valid/out_ready ps2mct_out_t (one result per request)
//  cfg_      in    cfg_we              cfg_index, cfg_wdata (screen size)
//
//  Input register, then decode/add/clamp into the result register and
//  tracker state. One request per cycle sustained while out_ready is high.
//  Synchronous active-low reset clears state and phase and restores the screen size defaults.
//  A held result stalls the decode stage; the input register still takes
//  one request while the result waits.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_cursor_tracker_defines.svh"

module ps2_mouse_packet_cursor_tracker
  import ps2mct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  ps2mct_in_t        in_data,

  output logic              out_valid,
  input  logic              out_ready,
  output ps2mct_out_t       out_data,

  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic             s1_valid_r, s1_valid_nxt;
  ps2mct_in_t       s1_data_r;
  logic             out_valid_r, out_valid_nxt;
  ps2mct_out_t      out_data_r;
  ps2mct_state_t    state_r;
  ps2mct_state_t    state_nxt;
  ps2mct_out_t      result;
  logic [CFG_W-1:0] hsize_r;
  logic [CFG_W-1:0] vsize_r;
  logic             adv;

  // Decode stage moves when the result register is free or being drained
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsize_r <= HSIZE_RST;
      vsize_r <= VSIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HSIZE: hsize_r <= cfg_wdata;
        CFG_VSIZE: vsize_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (adv)             s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data_r <= in_data;
  end

  // Decode and clamp
  ps2mct_step u_step (
    .item   (s1_data_r),
    .cur    (state_r),
    .hsize  (hsize_r),
    .vsize  (vsize_r),
    .nxt    (state_nxt),
    .result (result)
  );

  // Tracker state
  always_ff @(posedge clk) begin
    if (!rst_n)   state_r <= '0;
    else if (adv) state_r <= state_nxt;
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv)            out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `PS2MCT_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r, "decoded request not in result register")
  `PS2MCT_ASSERT_NEXT(a_s1_held, s1_valid_r && !adv, s1_valid_r, "stalled request dropped")
  `PS2MCT_ASSERT_NOW(a_kbd_only_fwd, out_valid_r && (out_data_r.event_kind != EV_KBD), out_data_r.keyboard_byte == 8'd0, "keyboard byte set on non-keyboard result")

endmodule
